FILE: rtl/core/register_bridge_ack_retransmit_unit_defines.svh
// Assertion macros for the register bridge
`ifndef REGISTER_BRIDGE_ACK_RETRANSMIT_UNIT_DEFINES_SVH
`define REGISTER_BRIDGE_ACK_RETRANSMIT_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle
`define RBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rba check failed");
// Assert that a condition holds on every cycle
`define RBA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rba check failed");
`endif

FILE: rtl/core/rba_pkg.sv
// Shared types and constants of the register bridge
package rba_pkg;
    localparam logic [7:0] PKT_READ  = 8'd0;
    localparam logic [7:0] PKT_WRITE = 8'd1;
    localparam logic [7:0] PKT_ACK   = 8'd2;
    localparam logic [3:0] LEN_READ  = 4'd6;
    localparam logic [3:0] LEN_WRITE = 4'd10;
    localparam logic [3:0] LEN_ACK   = 4'd2;
    localparam logic [1:0] KIND_ACKREQ = 2'd0;
    localparam logic [1:0] KIND_ANSWER = 2'd1;
    localparam logic [1:0] KIND_ACCESS = 2'd2;
    localparam logic [0:0] CFG_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_RETRY   = 1'b1;

    typedef enum logic [1:0] {OP_TICK, OP_ACK, OP_REQ} t_op;

    typedef struct packed {
        logic [7:0] pkt_id;
        logic [7:0] pkt_cmd;
        logic [3:0] pkt_len;
        logic       req_type;
        logic [31:0] reg_addr;
        logic [31:0] write_value;
        logic [31:0] reg_response;
    } t_in;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_id;
        logic        out_is_write;
        logic [31:0] out_data;
        logic [31:0] out_addr;
        logic        out_last;
    } t_out;

    // Classified command queued between front and back
    typedef struct packed {
        t_op         op;
        logic        is_write;
        logic [7:0]  id;
        logic [31:0] addr;
        logic [31:0] wval;
        logic [31:0] resp;
    } t_cmd;
endpackage

FILE: rtl/core/rba_if.sv
// Valid/ready channel interface
interface rba_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/register_bridge_ack_retransmit_unit.sv
// Register bridge with per-slot stop-and-wait delivery: an item is a received packet
// or a tick. A read/write gives one to three results, the first registered when the
// command leaves the queue; a tick walks the slot table one slot a cycle while no
// resend waits for the output register, in the single sequencer in the back part.
// A two-entry queue parts front and back.
`include "register_bridge_ack_retransmit_unit_defines.svh"
module register_bridge_ack_retransmit_unit import rba_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rba_if.sink         in_ch,
    rba_if.source       out_ch,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    logic [7:0] r_timeout;
    logic [7:0] r_retry;
    logic       w_qv;
    logic       w_pop;
    t_cmd       w_qc;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'd1;
            r_retry   <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_RETRY:   r_retry   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_q_valid(w_qv), .o_q_cmd(w_qc), .i_q_pop(w_pop)
    );

    rba_back #(.SLOTS(SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_cmd(w_qc),
        .o_q_pop(w_pop), .i_timeout(r_timeout), .i_retry(r_retry), .out_ch(out_ch)
    );

    `RBA_ASSERT_NEXT(a_pop_needs_valid, i_clk, i_rst_n, w_pop, $past(w_qv))
    `RBA_ASSERT_ALWAYS(a_pop_valid, i_clk, i_rst_n, !w_pop || w_qv)
    `RBA_ASSERT_ALWAYS(a_kind_range, i_clk, i_rst_n, !out_ch.valid || out_ch.data.out_kind != 2'd3)
endmodule

FILE: rtl/core/rba_front.sv
// Front part: classify packets and queue commands
module rba_front import rba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rba_if.sink  in_ch,
    output logic o_q_valid,
    output t_cmd o_q_cmd,
    input  logic i_q_pop
);
    // Two-entry queue
    t_cmd        r_q [2];
    logic [1:0]  r_cnt;
    logic        r_rd;
    logic        r_wr;
    logic        w_push;
    logic        w_good;
    t_cmd        w_cmd;

    // Classify the packet
    always_comb begin
        w_cmd.is_write = (in_ch.data.pkt_cmd == PKT_WRITE);
        w_cmd.id       = in_ch.data.pkt_id;
        w_cmd.addr     = in_ch.data.reg_addr;
        w_cmd.wval     = in_ch.data.write_value;
        w_cmd.resp     = in_ch.data.reg_response;
        w_good         = 1'b1;
        w_cmd.op       = OP_REQ;
        if (in_ch.data.req_type) begin
            w_cmd.op = OP_TICK;
        end else if (in_ch.data.pkt_cmd == PKT_ACK && in_ch.data.pkt_len == LEN_ACK) begin
            w_cmd.op = OP_ACK;
        end else if (!((in_ch.data.pkt_cmd == PKT_READ && in_ch.data.pkt_len == LEN_READ) ||
                       (in_ch.data.pkt_cmd == PKT_WRITE &&
                        in_ch.data.pkt_len == LEN_WRITE))) begin
            w_good = 1'b0;
        end
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push      = in_ch.valid && in_ch.ready && w_good;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_cmd     = r_q[r_rd];

    // Hold queue entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

FILE: rtl/core/rba_back.sv
// Back part: slot table, register access and resend timer
module rba_back import rba_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    input  logic [7:0] i_timeout,
    input  logic [7:0] i_retry,
    rba_if.source      out_ch
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT = 8;

    typedef enum logic [2:0] {S_IDLE, S_ACKREQ, S_ANS, S_ACCESS, S_NEWANS, S_TICK} t_state;

    t_state      r_state;
    logic [SLOTS-1:0] r_busy;
    logic [7:0]  r_ident  [SLOTS];
    logic        r_write  [SLOTS];
    logic [31:0] r_answer [SLOTS];
    logic [7:0]  r_retries[SLOTS];
    logic [7:0]  r_elapsed[SLOTS];
    t_cmd        r_cmd;
    logic [SW-1:0] r_slot;
    logic [SW:0] r_tidx;
    logic [3:0]  r_nout;
    logic        r_ovalid;
    t_out        r_out;

    logic            w_hit;
    logic [SW-1:0]   w_hit_idx;
    logic            w_free;
    logic [SW-1:0]   w_free_idx;
    logic [SW-1:0]   w_ti;
    logic [7:0]      w_el;
    logic            w_due;
    logic            w_more;
    logic            w_slot_ok;
    logic            w_oslot;

    // Search the slots for a matching id and the lowest free one
    always_comb begin
        w_hit = 1'b0; w_hit_idx = '0; w_free = 1'b0; w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_busy[i] && r_ident[i] == i_q_cmd.id) begin
                w_hit = 1'b1; w_hit_idx = SW'(i);
            end
            if (!r_busy[i]) begin
                w_free = 1'b1; w_free_idx = SW'(i);
            end
        end
    end

    // One slot of the tick sweep
    assign w_ti    = r_tidx[SW-1:0];
    assign w_el    = (r_elapsed[w_ti] == 8'hFF) ? 8'hFF : r_elapsed[w_ti] + 8'd1;
    assign w_due   = r_busy[w_ti] && (w_el >= i_timeout);
    assign w_oslot = !r_ovalid || out_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (32'(i) > 32'(r_tidx) && r_busy[i] &&
                ((r_elapsed[i] == 8'hFF ? 8'hFF : r_elapsed[i] + 8'd1) >= i_timeout) &&
                (r_retries[i] < i_retry)) begin
                w_more = 1'b1;
            end
        end
        w_slot_ok = (r_nout < 4'(MAX_OUT));
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && w_oslot;

    // Hold state, slots and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= '0;
            r_ovalid <= 1'b0;
            r_tidx   <= '0;
            r_nout   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_retries[i] <= '0;
                r_elapsed[i] <= '0;
            end
        end else begin
            if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd <= i_q_cmd;
                        case (i_q_cmd.op)
                            OP_ACK: begin
                                if (w_hit) begin
                                    r_busy[w_hit_idx] <= 1'b0;
                                end
                            end
                            OP_REQ: begin
                                r_ovalid <= 1'b1;
                                r_out <= '{KIND_ACKREQ, i_q_cmd.id, 1'b0, 32'd0, 32'd0,
                                           !(w_hit || w_free)};
                                if (w_hit) begin
                                    r_slot <= w_hit_idx;
                                    r_retries[w_hit_idx] <= '0;
                                    r_elapsed[w_hit_idx] <= '0;
                                    r_state <= S_ANS;
                                end else if (w_free) begin
                                    r_slot <= w_free_idx;
                                    r_state <= S_ACCESS;
                                end
                            end
                            default: begin
                                r_tidx <= '0;
                                r_nout <= '0;
                                r_state <= S_TICK;
                            end
                        endcase
                    end
                end
                S_ANS: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_out <= '{KIND_ANSWER, r_ident[r_slot], r_write[r_slot],
                                   r_answer[r_slot], 32'd0, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_ACCESS: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_out <= '{KIND_ACCESS, r_cmd.id, r_cmd.is_write,
                                   r_cmd.is_write ? r_cmd.wval : 32'd0, r_cmd.addr, 1'b0};
                        r_busy[r_slot]    <= 1'b1;
                        r_ident[r_slot]   <= r_cmd.id;
                        r_write[r_slot]   <= r_cmd.is_write;
                        r_answer[r_slot]  <= r_cmd.resp;
                        r_retries[r_slot] <= '0;
                        r_elapsed[r_slot] <= '0;
                        r_state <= S_NEWANS;
                    end
                end
                S_NEWANS: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_out <= '{KIND_ANSWER, r_cmd.id, r_cmd.is_write, r_cmd.resp,
                                   32'd0, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_TICK: begin
                    // Visit one slot a cycle; a resend waits for the output register
                    if (!(w_due && r_retries[w_ti] < i_retry && w_slot_ok) || w_oslot) begin
                        if (r_busy[w_ti]) begin
                            r_elapsed[w_ti] <= w_el;
                            if (w_due) begin
                                if (r_retries[w_ti] < i_retry) begin
                                    if (w_slot_ok) begin
                                        r_retries[w_ti] <= r_retries[w_ti] + 8'd1;
                                        r_elapsed[w_ti] <= '0;
                                        r_nout <= r_nout + 4'd1;
                                        r_ovalid <= 1'b1;
                                        r_out <= '{KIND_ANSWER, r_ident[w_ti], r_write[w_ti],
                                                   r_answer[w_ti], 32'd0,
                                                   !w_more || (r_nout + 4'd1 >= 4'(MAX_OUT))};
                                    end
                                end else begin
                                    r_busy[w_ti] <= 1'b0;
                                end
                            end
                        end
                        if (r_tidx == (SW+1)'(SLOTS - 1) || SLOTS == 1) begin
                            r_state <= S_IDLE;
                        end
                        r_tidx <= r_tidx + (SW+1)'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb_register_bridge_ack_retransmit_unit.sv
// Testbench of the register bridge: random and directed items checked against a slot predictor
`timescale 1ns / 100ps
module tb_register_bridge_ack_retransmit_unit;
    import rba_pkg::*;

    localparam int NSLOT = 8;
    localparam int MAX_RES = 8;
    localparam int SETTLE_CYCLES = 2 * (NSLOT + 1) + 6;
    localparam int STALL_LIMIT = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = CFG_TIMEOUT;
    logic [7:0] i_cfg_data = 8'd0;

    rba_if #(.T(t_in))  in_ch ();
    rba_if #(.T(t_out)) out_ch ();

    register_bridge_ack_retransmit_unit #(.SLOTS(NSLOT)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted state of the bridge
    logic [7:0]  timeout_ticks;
    logic [7:0]  retry_limit;
    logic        sl_busy    [NSLOT];
    logic [7:0]  sl_ident   [NSLOT];
    logic        sl_write   [NSLOT];
    logic [31:0] sl_answer  [NSLOT];
    logic [7:0]  sl_retries [NSLOT];
    logic [7:0]  sl_elapsed [NSLOT];

    t_in  pending_items[$];
    t_out expected_results[$];
    int   error_count = 0;
    int   stall_cycles = 0;
    bit   idle_on = 1'b1;
    logic [7:0] id_pool [12];

    function automatic t_out make_result(logic [1:0] kind, logic [7:0] id, logic wr,
                                         logic [31:0] data, logic [31:0] addr);
        t_out r;
        r.out_kind = kind;
        r.out_id = id;
        r.out_is_write = wr;
        r.out_data = data;
        r.out_addr = addr;
        r.out_last = 1'b0;
        return r;
    endfunction

    function automatic int find_busy(logic [7:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (sl_busy[i] && sl_ident[i] == id) return i;
        return -1;
    endfunction

    // Work out the results of one accepted item and advance the slot table
    function automatic void bridge_predict(t_in it);
        t_out res[$];
        int   s;
        logic wr;
        if (it.req_type) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!sl_busy[i]) continue;
                if (sl_elapsed[i] != 8'hFF) sl_elapsed[i]++;
                if (sl_elapsed[i] < timeout_ticks) continue;
                if (sl_retries[i] < retry_limit) begin
                    if (res.size() >= MAX_RES) continue;
                    sl_retries[i]++;
                    sl_elapsed[i] = 8'd0;
                    res.push_back(make_result(KIND_ANSWER, sl_ident[i], sl_write[i],
                                              sl_answer[i], 32'd0));
                end else begin
                    sl_busy[i] = 1'b0;
                end
            end
        end else if (it.pkt_cmd == PKT_ACK && it.pkt_len == LEN_ACK) begin
            s = find_busy(it.pkt_id);
            if (s >= 0) sl_busy[s] = 1'b0;
        end else if ((it.pkt_cmd == PKT_READ && it.pkt_len == LEN_READ) ||
                     (it.pkt_cmd == PKT_WRITE && it.pkt_len == LEN_WRITE)) begin
            wr = (it.pkt_cmd == PKT_WRITE);
            s = find_busy(it.pkt_id);
            res.push_back(make_result(KIND_ACKREQ, it.pkt_id, 1'b0, 32'd0, 32'd0));
            if (s >= 0) begin
                sl_retries[s] = 8'd0;
                sl_elapsed[s] = 8'd0;
                res.push_back(make_result(KIND_ANSWER, sl_ident[s], sl_write[s],
                                          sl_answer[s], 32'd0));
            end else begin
                for (int i = 0; i < NSLOT && s < 0; i++)
                    if (!sl_busy[i]) s = i;
                if (s >= 0) begin
                    res.push_back(make_result(KIND_ACCESS, it.pkt_id, wr,
                                              wr ? it.write_value : 32'd0, it.reg_addr));
                    sl_busy[s] = 1'b1;
                    sl_ident[s] = it.pkt_id;
                    sl_write[s] = wr;
                    sl_answer[s] = it.reg_response;
                    sl_retries[s] = 8'd0;
                    sl_elapsed[s] = 8'd0;
                    res.push_back(make_result(KIND_ANSWER, it.pkt_id, wr,
                                              it.reg_response, 32'd0));
                end
            end
        end
        if (res.size() > 0) res[res.size() - 1].out_last = 1'b1;
        foreach (res[k]) expected_results.push_back(res[k]);
    endfunction

    // Build an item with random payload words
    function automatic t_in make_item(logic tick, logic [3:0] len, logic [7:0] id,
                                      logic [7:0] cmd);
        t_in it;
        it.req_type = tick;
        it.pkt_len = len;
        it.pkt_id = id;
        it.pkt_cmd = cmd;
        it.reg_addr = $urandom;
        it.write_value = $urandom;
        it.reg_response = $urandom;
        return it;
    endfunction

    function automatic t_in make_request(logic [7:0] id);
        if ($urandom_range(1)) return make_item(1'b0, LEN_WRITE, id, PKT_WRITE);
        return make_item(1'b0, LEN_READ, id, PKT_READ);
    endfunction

    // Queue a mix of requests, acks and ticks over a small id pool, with some noise
    task automatic queue_random(int count);
        int r;
        foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(255));
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 20)
                pending_items.push_back(make_item(1'b1, 4'($urandom), 8'($urandom),
                                        8'($urandom)));
            else if (r < 38)
                pending_items.push_back(make_item(1'b0, LEN_ACK,
                                        id_pool[$urandom_range(11)], PKT_ACK));
            else if (r < 80)
                pending_items.push_back(make_request(id_pool[$urandom_range(11)]));
            else if (r < 88)
                pending_items.push_back(make_request(8'($urandom_range(255))));
            else
                pending_items.push_back(make_item(1'b0, 4'($urandom), 8'($urandom),
                                        $urandom_range(1) ? 8'($urandom_range(3))
                                                          : 8'($urandom)));
        end
    endtask

    // Wait until every item is taken and every result has arrived, then settle
    task automatic drain;
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic write_config(logic [7:0] tmo, logic [7:0] lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_idx <= CFG_RETRY;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        timeout_ticks = tmo;
        retry_limit = lim;
    endtask

    // Input driver: hold a stalled item, otherwise offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                bridge_predict(pending_items.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                in_ch.valid <= 1'b1;
            end else if (pending_items.size() != 0 &&
                         !(idle_on && $urandom_range(99) < 10)) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_items[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each taken item with the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_r;
        t_out got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(idle_on && $urandom_range(99) < 10);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d id %0d", got.out_kind, got.out_id);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.out_kind !== exp_r.out_kind) begin
                        $error("out_kind expected %0d got %0d", exp_r.out_kind, got.out_kind);
                        error_count++;
                    end
                    if (got.out_id !== exp_r.out_id) begin
                        $error("out_id expected %0d got %0d", exp_r.out_id, got.out_id);
                        error_count++;
                    end
                    if (got.out_is_write !== exp_r.out_is_write) begin
                        $error("out_is_write expected %0d got %0d",
                               exp_r.out_is_write, got.out_is_write);
                        error_count++;
                    end
                    if (got.out_data !== exp_r.out_data) begin
                        $error("out_data expected %h got %h", exp_r.out_data, got.out_data);
                        error_count++;
                    end
                    if (got.out_addr !== exp_r.out_addr) begin
                        $error("out_addr expected %h got %h", exp_r.out_addr, got.out_addr);
                        error_count++;
                    end
                    if (got.out_last !== exp_r.out_last) begin
                        $error("out_last expected %0d got %0d", exp_r.out_last, got.out_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too long without any item moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and phases
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        timeout_ticks = 8'd1;
        retry_limit = 8'd10;
        for (int i = 0; i < NSLOT; i++) begin
            sl_busy[i] = 1'b0;
            sl_ident[i] = 8'd0;
            sl_write[i] = 1'b0;
            sl_answer[i] = 32'd0;
            sl_retries[i] = 8'd0;
            sl_elapsed[i] = 8'd0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config(8'd2, 8'd1);

        // Directed: field extremes, duplicates, acks, bad packets, full table, ticks
        pending_items.push_back('{pkt_id: 8'd0, pkt_cmd: PKT_READ, pkt_len: LEN_READ,
                                  req_type: 1'b0, reg_addr: '0, write_value: '0,
                                  reg_response: '0});
        pending_items.push_back('{pkt_id: 8'hFF, pkt_cmd: PKT_WRITE, pkt_len: LEN_WRITE,
                                  req_type: 1'b0, reg_addr: '1, write_value: '1,
                                  reg_response: '1});
        pending_items.push_back(make_item(1'b0, LEN_READ, 8'hFF, PKT_READ));
        pending_items.push_back(make_item(1'b0, LEN_ACK, 8'd0, PKT_ACK));
        pending_items.push_back(make_item(1'b0, LEN_ACK, 8'd77, PKT_ACK));
        pending_items.push_back(make_item(1'b0, LEN_WRITE, 8'd5, PKT_READ));
        pending_items.push_back(make_item(1'b0, 4'd15, 8'd5, PKT_WRITE));
        pending_items.push_back(make_item(1'b0, LEN_ACK, 8'd5, 8'hFF));
        for (int k = 1; k <= 9; k++)
            pending_items.push_back(make_request(8'(k * 16)));
        pending_items.push_back(make_item(1'b1, 4'd0, 8'd0, 8'd0));
        pending_items.push_back(make_item(1'b1, 4'd15, 8'hFF, 8'hFF));
        pending_items.push_back(make_item(1'b1, 4'd0, 8'd0, 8'd0));
        pending_items.push_back(make_item(1'b1, 4'd0, 8'd0, 8'd0));
        drain();

        // Random phases across register settings, one without idling
        write_config(8'd1, 8'd10);
        queue_random(50);
        drain();
        write_config(8'd255, 8'd255);
        queue_random(40);
        drain();
        write_config(8'd1, 8'd0);
        queue_random(40);
        drain();
        idle_on = 1'b0;
        write_config(8'd0, 8'd3);
        queue_random(50);
        drain();
        idle_on = 1'b1;
        write_config(8'd3, 8'd2);
        queue_random(70);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rba_pkg.sv
rtl/core/rba_if.sv
rtl/core/rba_front.sv
rtl/core/rba_back.sv
rtl/core/register_bridge_ack_retransmit_unit.sv
dv/tb_register_bridge_ack_retransmit_unit.sv
